@@ hdl/box_zone_warning_classifier_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the box zone warning classifier
// Clocked property checks that report through $error; they compile away
// when NO_ASSERTIONS is defined. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BOX_ZONE_WARNING_CLASSIFIER_MACROS_SVH
`define BOX_ZONE_WARNING_CLASSIFIER_MACROS_SVH
`ifndef NO_ASSERTIONS
// check while out of reset
`define BZW_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check at every edge, reset included
`define BZW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BZW_ASSERT_CLK(lbl, prop, msg)
`define BZW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/bzw_pkg.sv @@
// ----------------------------------------------------------------------------
// bzw_pkg
// Types, widths, register indexes and reset values of the box zone
// warning classifier.
// ----------------------------------------------------------------------------
package bzw_pkg;

  localparam int COORD_BITS    = 12;
  localparam int PT_BITS       = COORD_BITS + 1;  // corner sums reach 2*4095
  localparam int DIFF_BITS     = PT_BITS + 1;     // signed point-vertex deltas
  localparam int PROD_BITS     = 2 * DIFF_BITS;
  localparam int ZONE_REG_BITS = 4 * COORD_BITS;
  localparam int NUM_ZONES     = 3;
  localparam int NUM_POINTS    = 5;
  localparam int NUM_PAIRS     = 2 * NUM_ZONES;
  localparam int CFG_IDX_BITS  = 3;
  localparam int LEVEL_BITS    = 2;

  // zone slots, also the enable bit of each zone
  localparam int ZN_STOP    = 0;
  localparam int ZN_CAUTION = 1;
  localparam int ZN_WARNING = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_A    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STOP_B    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAUTION_A = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAUTION_B = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WARNING_A = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WARNING_B = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZONE_EN   = 3'd6;

  // reset vertex pairs, packed x0,y0,x1,y1 from the low end
  localparam logic [ZONE_REG_BITS-1:0] RST_STOP_A    = 48'd61850888929330;
  localparam logic [ZONE_REG_BITS-1:0] RST_STOP_B    = 48'd74229789246050;
  localparam logic [ZONE_REG_BITS-1:0] RST_CAUTION_A = 48'd48108335759410;
  localparam logic [ZONE_REG_BITS-1:0] RST_CAUTION_B = 48'd74229788426770;
  localparam logic [ZONE_REG_BITS-1:0] RST_WARNING_A = 48'd37801253109810;
  localparam logic [ZONE_REG_BITS-1:0] RST_WARNING_B = 48'd74229787812320;
  localparam logic [NUM_ZONES-1:0]     RST_ZONE_EN   = 3'd7;

  // level codes
  localparam logic [LEVEL_BITS-1:0] LVL_SAFE    = 2'd0;
  localparam logic [LEVEL_BITS-1:0] LVL_WARNING = 2'd1;
  localparam logic [LEVEL_BITS-1:0] LVL_CAUTION = 2'd2;
  localparam logic [LEVEL_BITS-1:0] LVL_STOP    = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_width;
    logic [COORD_BITS-1:0] box_height;
    logic                  last_in_frame;
  } box_in_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] box_level;
    logic [LEVEL_BITS-1:0] frame_level;
    logic                  frame_done;
  } box_out_t;

  typedef struct packed {
    logic [NUM_PAIRS-1:0][ZONE_REG_BITS-1:0] zone_pair;
    logic [NUM_ZONES-1:0]                    zone_en;
  } cfg_t;

  // zone match beat between the test stage and the frame tracker
  typedef struct packed {
    logic [NUM_ZONES-1:0] zone_hit;
    logic                 last;
  } hit_beat_t;

endpackage

@@ hdl/bzw_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bzw_cfg_regs
// Zone vertex and enable registers, written one beat at a time.
// ----------------------------------------------------------------------------
module bzw_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bzw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bzw_pkg::ZONE_REG_BITS-1:0] cfg_data,
  output bzw_pkg::cfg_t                    cfg
);

  logic [bzw_pkg::NUM_PAIRS-1:0][bzw_pkg::ZONE_REG_BITS-1:0] zone_pair_r;
  logic [bzw_pkg::NUM_ZONES-1:0]                             zone_en_r;

  assign cfg_ready     = 1'b1;
  assign cfg.zone_pair = zone_pair_r;
  assign cfg.zone_en   = zone_en_r;

  // load reset zones, then take writes; drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_pair_r[bzw_pkg::REG_STOP_A]    <= bzw_pkg::RST_STOP_A;
      zone_pair_r[bzw_pkg::REG_STOP_B]    <= bzw_pkg::RST_STOP_B;
      zone_pair_r[bzw_pkg::REG_CAUTION_A] <= bzw_pkg::RST_CAUTION_A;
      zone_pair_r[bzw_pkg::REG_CAUTION_B] <= bzw_pkg::RST_CAUTION_B;
      zone_pair_r[bzw_pkg::REG_WARNING_A] <= bzw_pkg::RST_WARNING_A;
      zone_pair_r[bzw_pkg::REG_WARNING_B] <= bzw_pkg::RST_WARNING_B;
      zone_en_r                           <= bzw_pkg::RST_ZONE_EN;
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        bzw_pkg::REG_STOP_A, bzw_pkg::REG_STOP_B,
        bzw_pkg::REG_CAUTION_A, bzw_pkg::REG_CAUTION_B,
        bzw_pkg::REG_WARNING_A, bzw_pkg::REG_WARNING_B: begin
          zone_pair_r[cfg_index] <= cfg_data;
        end
        bzw_pkg::REG_ZONE_EN: begin
          zone_en_r <= cfg_data[bzw_pkg::NUM_ZONES-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/bzw_zone_test.sv @@
// ----------------------------------------------------------------------------
// bzw_zone_test
// Crossing-number test of one point against one closed zone; a point on
// an edge or vertex counts as inside.
// ----------------------------------------------------------------------------
module bzw_zone_test #(
  parameter int ZONE_VERTICES = 4
) (
  input  logic [bzw_pkg::ZONE_REG_BITS-1:0] pair_a,
  input  logic [bzw_pkg::ZONE_REG_BITS-1:0] pair_b,
  input  logic [bzw_pkg::PT_BITS-1:0]       pt_x,
  input  logic [bzw_pkg::PT_BITS-1:0]       pt_y,
  output logic                              pt_in
);

  localparam int CB = bzw_pkg::COORD_BITS;
  localparam int DB = bzw_pkg::DIFF_BITS;
  localparam int PB = bzw_pkg::PROD_BITS;

  logic signed [DB-1:0] vx [4];
  logic signed [DB-1:0] vy [4];
  logic signed [DB-1:0] px;
  logic signed [DB-1:0] py;
  logic [ZONE_VERTICES-1:0] on_e;
  logic [ZONE_VERTICES-1:0] cross_e;

  // unpack the four stored vertices
  assign vx[0] = signed'({2'b00, pair_a[0*CB +: CB]});
  assign vy[0] = signed'({2'b00, pair_a[1*CB +: CB]});
  assign vx[1] = signed'({2'b00, pair_a[2*CB +: CB]});
  assign vy[1] = signed'({2'b00, pair_a[3*CB +: CB]});
  assign vx[2] = signed'({2'b00, pair_b[0*CB +: CB]});
  assign vy[2] = signed'({2'b00, pair_b[1*CB +: CB]});
  assign vx[3] = signed'({2'b00, pair_b[2*CB +: CB]});
  assign vy[3] = signed'({2'b00, pair_b[3*CB +: CB]});
  assign px    = signed'({1'b0, pt_x});
  assign py    = signed'({1'b0, pt_y});

  // one edge per vertex, from the previous vertex; extra vertices repeat the last
  for (genvar i = 0; i < ZONE_VERTICES; i++) begin : g_edge
    localparam int IA = (i + ZONE_VERTICES - 1) % ZONE_VERTICES;
    localparam int KA = (IA < 4) ? IA : 3;
    localparam int KB = (i < 4) ? i : 3;

    logic signed [DB-1:0] ax, ay, bx, by;
    logic signed [DB-1:0] dy_pa, dx_ba, dx_pa, dy_ba;
    logic signed [PB-1:0] prod_l, prod_r, d;
    logic skip, on_skip, d_zero, d_neg;

    assign ax = vx[KA];
    assign ay = vy[KA];
    assign bx = vx[KB];
    assign by = vy[KB];

    // edge does not straddle the point's row, or lies wholly left of it
    assign skip = (ay <= py && by <= py) || (ay > py && by > py) || (ax < px && bx < px);

    // on the far vertex, or along a horizontal edge through the point
    assign on_skip = (py == by) && ((px == bx) || ((py == ay) &&
                     ((ax <= px && px <= bx) || (bx <= px && px <= ax))));

    // side of the point relative to the edge
    assign dy_pa  = py - ay;
    assign dx_ba  = bx - ax;
    assign dx_pa  = px - ax;
    assign dy_ba  = by - ay;
    assign prod_l = PB'(dy_pa) * PB'(dx_ba);
    assign prod_r = PB'(dx_pa) * PB'(dy_ba);
    assign d      = prod_l - prod_r;
    assign d_zero = (d == '0);
    assign d_neg  = d[PB-1];

    assign on_e[i]    = skip ? on_skip : d_zero;
    assign cross_e[i] = !skip && !d_zero && ((by < ay) ? d_neg : !d_neg);
  end

  assign pt_in = (|on_e) | (^cross_e);

endmodule

@@ hdl/bzw_frame_track.sv @@
// ----------------------------------------------------------------------------
// bzw_frame_track
// Resolves the box level from the zone matches, keeps the frame maximum
// and holds the result register.
// ----------------------------------------------------------------------------
`include "box_zone_warning_classifier_macros.svh"

module bzw_frame_track (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bzw_pkg::hit_beat_t beat,
  output logic               out_valid,
  input  logic               out_ready,
  output bzw_pkg::box_out_t  out_data
);

  logic                           out_valid_r, out_valid_nxt;
  bzw_pkg::box_out_t              out_data_r, out_data_nxt;
  logic [bzw_pkg::LEVEL_BITS-1:0] run_max_r, run_max_nxt;
  logic [bzw_pkg::LEVEL_BITS-1:0] level;
  logic [bzw_pkg::LEVEL_BITS-1:0] frame;
  logic                           load;

  assign in_ready  = !out_valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // pick the most severe matching zone, fold it into the frame maximum
  always_comb begin
    if (beat.zone_hit[bzw_pkg::ZN_STOP]) begin
      level = bzw_pkg::LVL_STOP;
    end else if (beat.zone_hit[bzw_pkg::ZN_CAUTION]) begin
      level = bzw_pkg::LVL_CAUTION;
    end else if (beat.zone_hit[bzw_pkg::ZN_WARNING]) begin
      level = bzw_pkg::LVL_WARNING;
    end else begin
      level = bzw_pkg::LVL_SAFE;
    end
    frame = (run_max_r > level) ? run_max_r : level;

    out_data_nxt.box_level   = level;
    out_data_nxt.frame_level = frame;
    out_data_nxt.frame_done  = beat.last;

    run_max_nxt   = run_max_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      run_max_nxt   = beat.last ? bzw_pkg::LVL_SAFE : frame;
      out_valid_nxt = 1'b1;
    end
  end

  // hold control state; payload loads on each beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      run_max_r   <= bzw_pkg::LVL_SAFE;
    end else begin
      out_valid_r <= out_valid_nxt;
      run_max_r   <= run_max_nxt;
    end
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  `BZW_ASSERT_CLK(a_clear_after_last, load && beat.last |=> run_max_r == bzw_pkg::LVL_SAFE, "frame maximum not cleared after last box")
  `BZW_ASSERT_CLK(a_frame_covers_box, out_valid_r |-> out_data_r.frame_level >= out_data_r.box_level, "frame level below box level")
  `BZW_ASSERT_CLK(a_load_shows, load |=> out_valid_r, "loaded result not presented")

endmodule

@@ hdl/box_zone_warning_classifier.sv @@
// ----------------------------------------------------------------------------
// box_zone_warning_classifier
// Classifies bounding boxes against stop, caution and warning zones and
// tracks the most severe level of each frame.
// ----------------------------------------------------------------------------
// One box is taken every cycle while the output is not stalled, and one
// result leaves for every box. A box is registered on acceptance, its five
// test points are checked against all three zones by fifteen parallel
// crossing-number testers (one multiplier pair per zone edge) whose match
// bits are registered, and the level and frame maximum are then resolved
// into the result register, from which the result is presented. The user
// must write zone registers through the cfg port only while no box is in
// flight; the block does not enforce this. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
`include "box_zone_warning_classifier_macros.svh"

module box_zone_warning_classifier #(
  parameter int ZONE_VERTICES = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bzw_pkg::box_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bzw_pkg::box_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bzw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bzw_pkg::ZONE_REG_BITS-1:0] cfg_data
);

  localparam int NZ = bzw_pkg::NUM_ZONES;
  localparam int NP = bzw_pkg::NUM_POINTS;
  localparam int PT = bzw_pkg::PT_BITS;

  bzw_pkg::cfg_t      cfg;
  logic               s0_valid_r, s0_valid_nxt;
  bzw_pkg::box_in_t   s0_box_r;
  logic               s1_valid_r, s1_valid_nxt;
  bzw_pkg::hit_beat_t s1_beat_r, s1_beat_nxt;
  logic               trk_ready;
  logic               in_fire, s0_move, s1_move, s1_open;
  logic [PT-1:0]      pt_x [NP];
  logic [PT-1:0]      pt_y [NP];
  logic [NZ-1:0][NP-1:0] pt_hit;

  bzw_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage handshakes
  assign s1_move  = s1_valid_r && trk_ready;
  assign s1_open  = !s1_valid_r || trk_ready;
  assign s0_move  = s0_valid_r && s1_open;
  assign in_ready = !s0_valid_r || s1_open;
  assign in_fire  = in_valid && in_ready;

  // form corners and center, halves truncated
  always_comb begin
    logic [PT-1:0] x, y, w, h;
    x = {1'b0, s0_box_r.box_left};
    y = {1'b0, s0_box_r.box_top};
    w = {1'b0, s0_box_r.box_width};
    h = {1'b0, s0_box_r.box_height};
    pt_x[0] = x;            pt_y[0] = y;
    pt_x[1] = x + w;        pt_y[1] = y;
    pt_x[2] = x;            pt_y[2] = y + h;
    pt_x[3] = x + w;        pt_y[3] = y + h;
    pt_x[4] = x + (w >> 1); pt_y[4] = y + (h >> 1);
  end

  // test every point against every zone
  for (genvar z = 0; z < NZ; z++) begin : g_zone
    for (genvar p = 0; p < NP; p++) begin : g_point
      bzw_zone_test #(
        .ZONE_VERTICES (ZONE_VERTICES)
      ) u_test (
        .pair_a (cfg.zone_pair[2*z]),
        .pair_b (cfg.zone_pair[2*z+1]),
        .pt_x   (pt_x[p]),
        .pt_y   (pt_y[p]),
        .pt_in  (pt_hit[z][p])
      );
    end
  end

  // mask disabled zones
  always_comb begin
    for (int z = 0; z < NZ; z++) begin
      s1_beat_nxt.zone_hit[z] = cfg.zone_en[z] && (|pt_hit[z]);
    end
    s1_beat_nxt.last = s0_box_r.last_in_frame;
    s0_valid_nxt = in_fire || (s0_valid_r && !s0_move);
    s1_valid_nxt = s0_move || (s1_valid_r && !s1_move);
  end

  // advance the input and match registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_fire) begin
      s0_box_r <= in_data;
    end
    if (s0_move) begin
      s1_beat_r <= s1_beat_nxt;
    end
  end

  bzw_frame_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r),
    .in_ready  (trk_ready),
    .beat      (s1_beat_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `BZW_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !s0_valid_r && !s1_valid_r, "pipeline not empty after reset")
  `BZW_ASSERT_CLK(a_fire_fills, in_fire |=> s0_valid_r, "accepted box lost from input register")
  `BZW_ASSERT_CLK(a_s1_stall_holds, s1_valid_r && !trk_ready |=> s1_valid_r && $stable(s1_beat_r), "stalled match beat changed")
  `BZW_ASSERT_CLK(a_s0_stall_holds, s0_valid_r && !s1_open |=> s0_valid_r && $stable(s0_box_r), "stalled box changed")

endmodule
